>>> hw/rtl/sdepq_pkg.sv
// Shared types and codes for the stable double-ended priority queue.
// Depends on nothing; used by sdepq_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sdepq_pkg;

  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT       = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_FRONT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_BACK  = 2'd2;

  localparam int DEPTH_DEFAULT          = 16;
  localparam int DATA_WIDTH_DEFAULT     = 32;
  localparam int PRIORITY_WIDTH_DEFAULT = 16;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic              en;
    logic [FUNC_W-1:0] func;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sdepq_cell.sv
// One slot of the sorted shift-register chain: holds a priority and a payload.
// Depends on sdepq_pkg for the request codes and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sdepq_cell #(
  parameter int DATA_WIDTH     = sdepq_pkg::DATA_WIDTH_DEFAULT,
  parameter int PRIORITY_WIDTH = sdepq_pkg::PRIORITY_WIDTH_DEFAULT
) (
  input  wire                             clk,
  input  sdepq_pkg::cell_ctrl_t           ctrl,
  input  wire        [DATA_WIDTH-1:0]     new_data,
  input  wire signed [PRIORITY_WIDTH-1:0] new_prio,
  input  wire                             occ,
  input  wire                             left_le,
  input  wire        [DATA_WIDTH-1:0]     left_data,
  input  wire signed [PRIORITY_WIDTH-1:0] left_prio,
  input  wire        [DATA_WIDTH-1:0]     right_data,
  input  wire signed [PRIORITY_WIDTH-1:0] right_prio,
  output logic                            le,
  output logic       [DATA_WIDTH-1:0]     data,
  output logic signed [PRIORITY_WIDTH-1:0] prio
);

  logic        [DATA_WIDTH-1:0]     data_r, data_nxt;
  logic signed [PRIORITY_WIDTH-1:0] prio_r, prio_nxt;

  // An occupied slot whose priority is not above the new one keeps its place,
  // which puts a new entry behind all of its equals.
  assign le   = occ && (prio_r <= new_prio);
  assign data = data_r;
  assign prio = prio_r;

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (ctrl.en) begin
      unique case (ctrl.func)
        sdepq_pkg::FUNC_INSERT: begin
          if (!le) begin
            if (left_le) begin
              data_nxt = new_data;
              prio_nxt = new_prio;
            end else begin
              data_nxt = left_data;
              prio_nxt = left_prio;
            end
          end
        end
        sdepq_pkg::FUNC_REMOVE_FRONT: begin
          data_nxt = right_data;
          prio_nxt = right_prio;
        end
        default: begin
          data_nxt = data_r;
          prio_nxt = prio_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/stable_double_ended_priority_queue.sv
// Top level of the stable double-ended priority queue: a chain of sdepq_cell
// slots, the entry counter and the result register. Depends on sdepq_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The queue holds up to DEPTH entries sorted by ascending signed priority;
// a lower number is served first, and equal priorities leave in the order
// they arrived. Each item on the input channel (in_valid / in_ready) carries
// in_func: insert, remove front (lowest number) or remove back (highest).
// Every item produces exactly one result item on the output channel
// (out_valid / out_ready) with the removed entry, a rejected flag for an
// insert into a full queue, the occupancy and the back entry's priority.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while results are drained, set by the cell chain, where
// every slot compares against the new priority and shifts toward its
// neighbor in the same cycle. A new item is accepted whenever the result
// register is empty or is being drained in that cycle, so a stalled receiver
// holds the input off only while its result waits. Occupancy comes from the
// entry counter and back priority straight from the cell chain; neither can
// change while a result waits. Reset empties the queue and result register;
// slot contents are left as they are and are never read before being written.

module stable_double_ended_priority_queue #(
  parameter int DEPTH          = sdepq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH     = sdepq_pkg::DATA_WIDTH_DEFAULT,
  parameter int PRIORITY_WIDTH = sdepq_pkg::PRIORITY_WIDTH_DEFAULT,
  localparam int CNT_W         = $clog2(DEPTH + 1)
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire        [sdepq_pkg::FUNC_W-1:0] in_func,
  input  wire        [DATA_WIDTH-1:0]       in_entry_data,
  input  wire signed [PRIORITY_WIDTH-1:0]   in_entry_priority,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              out_out_valid,
  output logic       [DATA_WIDTH-1:0]       out_out_data,
  output logic signed [PRIORITY_WIDTH-1:0]  out_out_priority,
  output logic                              out_rejected,
  output logic       [CNT_W-1:0]            out_occupancy,
  output logic signed [PRIORITY_WIDTH-1:0]  out_last_priority
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             full;
  logic             empty;
  logic             is_insert;
  logic             is_front;
  logic             is_back;

  sdepq_pkg::cell_ctrl_t ctrl;

  // Occupancy of each slot, with an always-empty slot past the end.
  logic [DEPTH:0]   occ;
  logic [DEPTH-1:0] is_last;
  logic [DEPTH-1:0] cell_le;
  logic        [DATA_WIDTH-1:0]     cell_data [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] cell_prio [DEPTH];

  logic        [DATA_WIDTH-1:0]     back_data;
  logic signed [PRIORITY_WIDTH-1:0] back_prio;

  logic                             out_valid_r;
  logic                             hit_r, hit_nxt;
  logic        [DATA_WIDTH-1:0]     rdata_r, rdata_nxt;
  logic signed [PRIORITY_WIDTH-1:0] rprio_r, rprio_nxt;
  logic                             rej_r, rej_nxt;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign is_insert = (in_func == sdepq_pkg::FUNC_INSERT);
  assign is_front  = (in_func == sdepq_pkg::FUNC_REMOVE_FRONT);
  assign is_back   = (in_func == sdepq_pkg::FUNC_REMOVE_BACK);

  // A rejected insert must leave the chain untouched. A removal from an empty
  // queue may shift stale slots, which stay unoccupied and are never read.
  assign ctrl.en   = accept && !(is_insert && full);
  assign ctrl.func = in_func;

  assign occ[DEPTH] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                             left_le;
      logic        [DATA_WIDTH-1:0]     left_data;
      logic signed [PRIORITY_WIDTH-1:0] left_prio;
      logic        [DATA_WIDTH-1:0]     right_data;
      logic signed [PRIORITY_WIDTH-1:0] right_prio;

      assign occ[gi]     = (CNT_W'(gi) < count_r);
      assign is_last[gi] = occ[gi] && !occ[gi+1];

      if (gi == 0) begin : g_head
        assign left_le   = 1'b1;
        assign left_data = '0;
        assign left_prio = '0;
      end else begin : g_body
        assign left_le   = cell_le[gi-1];
        assign left_data = cell_data[gi-1];
        assign left_prio = cell_prio[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_data = '0;
        assign right_prio = '0;
      end else begin : g_inner
        assign right_data = cell_data[gi+1];
        assign right_prio = cell_prio[gi+1];
      end

      sdepq_cell #(
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_data   (in_entry_data),
        .new_prio   (in_entry_priority),
        .occ        (occ[gi]),
        .left_le    (left_le),
        .left_data  (left_data),
        .left_prio  (left_prio),
        .right_data (right_data),
        .right_prio (right_prio),
        .le         (cell_le[gi]),
        .data       (cell_data[gi]),
        .prio       (cell_prio[gi])
      );
    end
  endgenerate

  // The back entry is the one occupied slot whose right neighbor is empty;
  // with an empty queue no slot qualifies and both words read as zero.
  always_comb begin
    back_data = '0;
    back_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | (is_last[i] ? cell_data[i] : '0);
      back_prio = back_prio | (is_last[i] ? cell_prio[i] : '0);
    end
  end

  always_comb begin
    count_nxt = count_r;
    hit_nxt   = 1'b0;
    rdata_nxt = '0;
    rprio_nxt = '0;
    rej_nxt   = 1'b0;
    if (is_insert) begin
      rej_nxt = full;
      if (!full) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_front) begin
      if (!empty) begin
        hit_nxt   = 1'b1;
        rdata_nxt = cell_data[0];
        rprio_nxt = cell_prio[0];
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (is_back) begin
      if (!empty) begin
        hit_nxt   = 1'b1;
        rdata_nxt = back_data;
        rprio_nxt = back_prio;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r   <= hit_nxt;
      rdata_r <= rdata_nxt;
      rprio_r <= rprio_nxt;
      rej_r   <= rej_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_out_valid     = hit_r;
  assign out_out_data      = rdata_r;
  assign out_out_priority  = rprio_r;
  assign out_rejected      = rej_r;
  assign out_occupancy     = count_r;
  assign out_last_priority = back_prio;

  // The counter never runs past the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // An insert into a full queue is flagged and leaves the count alone.
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_insert && full) |=> (out_rejected && count_r == $past(count_r)))
    else $error("insert into full queue not rejected cleanly");

  // A removal from a non-empty queue returns an entry and frees one slot.
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (is_front || is_back) && !empty)
      |=> (out_out_valid && count_r == $past(count_r) - CNT_W'(1)))
    else $error("removal did not free exactly one slot");

  // A result never both returns an entry and reports a rejected insert.
  a_hit_xor_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_out_valid && out_rejected))
    else $error("result both returned an entry and rejected an insert");

  // Occupied slots stay in ascending priority order.
  generate
    for (gi = 0; gi < DEPTH - 1; gi++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        occ[gi+1] |-> (cell_prio[gi] <= cell_prio[gi+1]))
        else $error("slot chain out of priority order");
    end
  endgenerate

endmodule

`default_nettype wire

>>> bench/sdepq_order_checker.sv
// Checker for the stable double-ended priority queue: watches both channels,
// predicts every result item and compares it field by field. Depends on sdepq_pkg.
`timescale 1ns / 1ps

module sdepq_order_checker #(
  parameter int DEPTH          = sdepq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH     = sdepq_pkg::DATA_WIDTH_DEFAULT,
  parameter int PRIORITY_WIDTH = sdepq_pkg::PRIORITY_WIDTH_DEFAULT,
  localparam int CNT_W         = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [sdepq_pkg::FUNC_W-1:0]     in_func,
  input  logic [DATA_WIDTH-1:0]            in_entry_data,
  input  logic signed [PRIORITY_WIDTH-1:0] in_entry_priority,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_out_valid,
  input  logic [DATA_WIDTH-1:0]            out_out_data,
  input  logic signed [PRIORITY_WIDTH-1:0] out_out_priority,
  input  logic                             out_rejected,
  input  logic [CNT_W-1:0]                 out_occupancy,
  input  logic signed [PRIORITY_WIDTH-1:0] out_last_priority,
  output int                               fail_count,
  output int                               pending
);

  import sdepq_pkg::*;

  typedef struct packed {
    logic                             got_entry;
    logic [DATA_WIDTH-1:0]            data;
    logic signed [PRIORITY_WIDTH-1:0] prio;
    logic                             rejected;
    logic [CNT_W-1:0]                 occupancy;
    logic signed [PRIORITY_WIDTH-1:0] back_prio;
  } queue_result_t;

  // Sorted copy of the queue contents, front at index 0.
  logic signed [PRIORITY_WIDTH-1:0] held_prio [DEPTH];
  logic [DATA_WIDTH-1:0]            held_data [DEPTH];
  int                               held_count;
  queue_result_t                    expected_results [$];

  task automatic predict_request(input logic [FUNC_W-1:0]             func,
                                 input logic [DATA_WIDTH-1:0]            data,
                                 input logic signed [PRIORITY_WIDTH-1:0] prio);
    queue_result_t r;
    int            pos;
    int            i;
    r = '0;
    case (func)
      FUNC_INSERT: begin
        if (held_count >= DEPTH) begin
          r.rejected = 1'b1;
        end else begin
          // An equal priority goes behind the ones already held.
          pos = 0;
          while (pos < held_count && held_prio[pos] <= prio) pos++;
          for (i = held_count; i > pos; i--) begin
            held_prio[i] = held_prio[i-1];
            held_data[i] = held_data[i-1];
          end
          held_prio[pos] = prio;
          held_data[pos] = data;
          held_count++;
        end
      end
      FUNC_REMOVE_FRONT: begin
        if (held_count > 0) begin
          r.got_entry = 1'b1;
          r.data      = held_data[0];
          r.prio      = held_prio[0];
          for (i = 1; i < held_count; i++) begin
            held_prio[i-1] = held_prio[i];
            held_data[i-1] = held_data[i];
          end
          held_count--;
        end
      end
      FUNC_REMOVE_BACK: begin
        if (held_count > 0) begin
          held_count--;
          r.got_entry = 1'b1;
          r.data      = held_data[held_count];
          r.prio      = held_prio[held_count];
        end
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(held_count);
    r.back_prio = (held_count > 0) ? held_prio[held_count-1] : '0;
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    queue_result_t r;
    if (expected_results.size() == 0) begin
      $error("result item arrived with no request outstanding");
      fail_count++;
    end else begin
      r = expected_results.pop_front();
      compare_field("out_valid", r.got_entry, out_out_valid);
      compare_field("out_data", r.data, out_out_data);
      compare_field("out_priority", r.prio, out_out_priority);
      compare_field("rejected", r.rejected, out_rejected);
      compare_field("occupancy", r.occupancy, out_occupancy);
      compare_field("last_priority", r.back_prio, out_last_priority);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_func, in_entry_data, in_entry_priority);
      end
      if (out_valid && out_ready) begin
        check_result();
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> bench/stable_double_ended_priority_queue_tb.sv
// Top of the testbench for the stable double-ended priority queue: clock,
// reset, request stimulus, receiver stalls and the verdict.
// Depends on sdepq_pkg, the block itself and sdepq_order_checker.
`timescale 1ns / 1ps

module stable_double_ended_priority_queue_tb;

  import sdepq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int DW    = DATA_WIDTH_DEFAULT;
  localparam int PW    = PRIORITY_WIDTH_DEFAULT;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // The fourth selector value is not an operation; the block must treat it
  // as a no-op that still reports occupancy and back priority.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 450;
  localparam int RX_HOLD_CYCLES = 300;
  // Cycles without any accepted item before the run is declared hung. The
  // longest legal quiet stretch is the receiver hold-off above.
  localparam int STALL_LIMIT    = 2000;

  logic                    clk;
  logic                    rst_n             = 1'b0;
  logic                    in_valid          = 1'b0;
  logic                    in_ready;
  logic [FUNC_W-1:0]       in_func           = FUNC_INSERT;
  logic [DW-1:0]           in_entry_data     = '0;
  logic signed [PW-1:0]    in_entry_priority = '0;
  logic                    out_valid;
  logic                    out_ready         = 1'b0;
  logic                    out_out_valid;
  logic [DW-1:0]           out_out_data;
  logic signed [PW-1:0]    out_out_priority;
  logic                    out_rejected;
  logic [CNT_W-1:0]        out_occupancy;
  logic signed [PW-1:0]    out_last_priority;

  int   fail_count;
  int   pending;
  int   stall_cycles = 0;

  // Both sides idle at random while this is set; it is cleared for one long
  // stretch of the random part so back-to-back traffic is covered too.
  logic idle_on     = 1'b1;
  // Asks the receiver for one long hold-off while the sender keeps going.
  logic rx_hold_req = 1'b0;

  stable_double_ended_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_data    (in_entry_data),
    .in_entry_priority(in_entry_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_valid    (out_out_valid),
    .out_out_data     (out_out_data),
    .out_out_priority (out_out_priority),
    .out_rejected     (out_rejected),
    .out_occupancy    (out_occupancy),
    .out_last_priority(out_last_priority)
  );

  sdepq_order_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_data    (in_entry_data),
    .in_entry_priority(in_entry_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_valid    (out_out_valid),
    .out_out_data     (out_out_data),
    .out_out_priority (out_out_priority),
    .out_rejected     (out_rejected),
    .out_occupancy    (out_occupancy),
    .out_last_priority(out_last_priority),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver. It stalls in about a third of the cycles while idling is on,
  // and once takes a long hold-off that it counts itself. Because the block
  // has a single result register, that hold-off backs up into in_ready.
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= !(idle_on && ($urandom_range(99) < 36));
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("stable_double_ended_priority_queue_tb failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offers one request item and returns at the edge that accepts it. Any
  // gap is taken first with valid low, so valid is never dropped and raised
  // in the same time step. All sampling happens right at the edge, before
  // the block's registers update.
  task automatic offer_request(input logic [FUNC_W-1:0] func,
                               input logic [DW-1:0]     data,
                               input logic signed [PW-1:0] prio);
    int gap;
    gap = 0;
    while (idle_on && ($urandom_range(99) < 36)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_entry_data     <= data;
    in_entry_priority <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drops valid and waits until every predicted result item has come back.
  // The count is read on the falling edge, where it is stable.
  task automatic wait_for_all_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Mostly small priorities so that ties, and with them the arrival order
  // among equals, come up often; now and then the full range or an extreme.
  function automatic logic signed [PW-1:0] pick_priority();
    case ($urandom_range(9))
      0:       pick_priority = PW'($urandom);
      1:       pick_priority = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: pick_priority = $signed(PW'($urandom_range(6))) - 16'sd3;
    endcase
  endfunction

  initial begin : stimulus
    int                k;
    int                n;
    int                insert_pct;
    int                roll;
    logic [FUNC_W-1:0] func;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Removals and the unused selector on an empty queue must
    // return nothing; payload and priority on those are don't-care inputs.
    offer_request(FUNC_REMOVE_FRONT, 32'hFFFF_FFFF, 16'sh7FFF);
    offer_request(FUNC_REMOVE_BACK, 32'h0, 16'sh8000);
    offer_request(FUNC_UNUSED, 32'hFFFF_FFFF, -16'sd1);
    // Extremes of payload and priority, then three equal priorities that
    // must later leave in their arrival order.
    offer_request(FUNC_INSERT, 32'hFFFF_FFFF, 16'sh7FFF);
    offer_request(FUNC_INSERT, 32'h0, 16'sh8000);
    offer_request(FUNC_INSERT, 32'hA1, 16'sd0);
    offer_request(FUNC_INSERT, 32'hA2, 16'sd0);
    offer_request(FUNC_INSERT, 32'hA3, 16'sd0);
    offer_request(FUNC_UNUSED, 32'h5555_5555, 16'sd0);
    offer_request(FUNC_REMOVE_BACK, 32'h0, 16'sd0);
    offer_request(FUNC_REMOVE_FRONT, 32'h0, 16'sd0);
    // Three entries are held; fill the queue and push one more into it,
    // which must be rejected without changing anything.
    for (k = 0; k < 14; k++) begin
      offer_request(FUNC_INSERT, 32'h100 + k, PW'(k % 4) - 16'sd1);
    end
    offer_request(FUNC_REMOVE_FRONT, 32'h0, 16'sd0);
    offer_request(FUNC_REMOVE_FRONT, 32'h0, 16'sd0);

    // Sender pause with everything drained before the random part.
    wait_for_all_results();

    // Random part. Every thirty items the mix leans toward filling, toward
    // draining or stays balanced, so both the full and the empty queue are
    // reached again and again.
    insert_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 90;
        endcase
      end
      idle_on <= !(n >= 150 && n < 250);
      if (n == 320) rx_hold_req <= 1'b1;
      if (n == 100 || n == 400) wait_for_all_results();

      roll = $urandom_range(99);
      if (roll < 4) begin
        func = FUNC_UNUSED;
      end else if (roll < 4 + (insert_pct * 96) / 100) begin
        func = FUNC_INSERT;
      end else if ($urandom_range(1)) begin
        func = FUNC_REMOVE_FRONT;
      end else begin
        func = FUNC_REMOVE_BACK;
      end
      offer_request(func, $urandom, pick_priority());
    end

    // Let the last result come back, plus a few cycles for anything stray.
    wait_for_all_results();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("stable_double_ended_priority_queue_tb passed");
    end else begin
      $display("stable_double_ended_priority_queue_tb failed");
    end
    $finish;
  end

endmodule
